// File: sv/tkrs_pkg.sv
// Shared types and constants for the top-k row selector.
package tkrs_pkg;
  localparam int MaxKeep = 16;
  localparam int KeyBits = 32;
  localparam int TagBits = 16;
  localparam int IdxBits = $clog2(MaxKeep);
  localparam int CntBits = $clog2(MaxKeep + 1);

  localparam logic [1:0] RegKeepLimit = 2'd0;
  localparam logic [1:0] RegPrimAsc   = 2'd1;
  localparam logic [1:0] RegSecAsc    = 2'd2;
  localparam logic [1:0] RegSecUse    = 2'd3;

  typedef struct packed {
    logic prim_asc;
    logic sec_asc;
    logic sec_use;
  } order_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load_row;     // latch the incoming row
    logic scan_clear;   // start a scan
    logic worst_step;   // worst search: compare one entry
    logic best_step;    // best search: compare one unemitted entry
    logic append;       // write latched row at held count
    logic replace;      // count a drop, delete worst, append if not worse
    logic emit_load;    // move best entry (or empty marker) into out register
    logic clear_run;    // end of emission
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             full;
    logic             empty;
    logic             scan_done;
    logic             emit_last;
  } dp_status_t;

  // 1 when row a ranks strictly worse than row b
  function automatic logic worse(input order_cfg_t c,
                                 input logic [KeyBits-1:0] ap, input logic [KeyBits-1:0] as,
                                 input logic [KeyBits-1:0] bp, input logic [KeyBits-1:0] bs);
    logic r;
    r = 1'b0;
    if (ap != bp) r = ((ap < bp) != c.prim_asc);
    else if (c.sec_use && (as != bs)) r = ((as < bs) != c.sec_asc);
    return r;
  endfunction
endpackage

// File: sv/tkrs_datapath.sv
// Row store, worst/best scan and output register of the top-k row selector.
module tkrs_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tkrs_pkg::dp_cmd_t            cmd_i,
  output tkrs_pkg::dp_status_t         status_o,
  input  tkrs_pkg::order_cfg_t         ord_i,
  input  logic [4:0]                   keep_limit_i,
  input  logic [tkrs_pkg::KeyBits-1:0] in_prim_i,
  input  logic [tkrs_pkg::KeyBits-1:0] in_sec_i,
  input  logic [tkrs_pkg::TagBits-1:0] in_tag_i,
  output logic [tkrs_pkg::KeyBits-1:0] out_prim_o,
  output logic [tkrs_pkg::KeyBits-1:0] out_sec_o,
  output logic [tkrs_pkg::TagBits-1:0] out_tag_o,
  output logic                         out_last_o,
  output logic                         out_empty_o,
  output logic [31:0]                  out_cnt_o
);
  import tkrs_pkg::*;

  logic [KeyBits-1:0] prim_q [MaxKeep];
  logic [KeyBits-1:0] sec_q  [MaxKeep];
  logic [TagBits-1:0] tag_q  [MaxKeep];
  logic [MaxKeep-1:0] done_q, done_d;   // already emitted
  logic [CntBits-1:0] cnt_q, cnt_d, eff_k, emitted_q, emitted_d;
  logic [31:0]        drop_q, drop_d;
  logic [KeyBits-1:0] rp_q, rs_q;
  logic [TagBits-1:0] rt_q;
  logic [IdxBits-1:0] ptr_q, ptr_d, sel_q, sel_d, best_q, best_d;
  logic               bhave_q, bhave_d;
  logic               cur_worse, cur_better, not_worse_in, last_emit;

  // effective limit: 0 acts as 1, clamp to MaxKeep
  always_comb begin
    if (keep_limit_i == 5'd0) eff_k = CntBits'(1);
    else if (32'(keep_limit_i) > MaxKeep) eff_k = CntBits'(MaxKeep);
    else eff_k = CntBits'(keep_limit_i);
  end

  always_comb begin
    // entry ptr no better than worst pick: latest of equal worst wins
    cur_worse  = !worse(ord_i, prim_q[sel_q], sec_q[sel_q], prim_q[ptr_q], sec_q[ptr_q]);
    // entry ptr strictly better than best pick: earliest of equals stays
    cur_better = worse(ord_i, prim_q[best_q], sec_q[best_q], prim_q[ptr_q], sec_q[ptr_q]);
  end

  assign not_worse_in = !worse(ord_i, rp_q, rs_q, prim_q[sel_q], sec_q[sel_q]);
  assign last_emit    = (emitted_q + CntBits'(1) >= cnt_q);

  assign status_o.full      = (cnt_q >= eff_k);
  assign status_o.empty     = (cnt_q == '0);
  assign status_o.scan_done = (CntBits'(ptr_q) + CntBits'(1) >= cnt_q);
  assign status_o.emit_last = last_emit;

  always_comb begin
    ptr_d = ptr_q; sel_d = sel_q; best_d = best_q; bhave_d = bhave_q;
    done_d = done_q; cnt_d = cnt_q; drop_d = drop_q; emitted_d = emitted_q;
    if (cmd_i.scan_clear) begin
      ptr_d = '0; sel_d = '0; best_d = '0; bhave_d = 1'b0;
    end
    if (cmd_i.worst_step) begin
      if (cur_worse) sel_d = ptr_q;
      ptr_d = ptr_q + IdxBits'(1);
    end
    if (cmd_i.best_step) begin
      if (!done_q[ptr_q] && (!bhave_q || cur_better)) begin
        best_d  = ptr_q;
        bhave_d = 1'b1;
      end
      ptr_d = ptr_q + IdxBits'(1);
    end
    if (cmd_i.append) cnt_d = cnt_q + CntBits'(1);
    if (cmd_i.replace) begin
      if (drop_q != 32'hFFFF_FFFF) drop_d = drop_q + 32'd1;
    end
    if (cmd_i.emit_load) begin
      done_d[best_q] = 1'b1;
      emitted_d = emitted_q + CntBits'(1);
    end
    if (cmd_i.clear_run) begin
      cnt_d = '0; drop_d = '0; done_d = '0; emitted_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; drop_q <= '0; done_q <= '0; emitted_q <= '0;
      ptr_q <= '0; sel_q <= '0; best_q <= '0; bhave_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; drop_q <= drop_d; done_q <= done_d; emitted_q <= emitted_d;
      ptr_q <= ptr_d; sel_q <= sel_d; best_q <= best_d; bhave_q <= bhave_d;
    end
  end

  // row store: shift-down delete plus append
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_row) begin
      rp_q <= in_prim_i; rs_q <= in_sec_i; rt_q <= in_tag_i;
    end
    if (cmd_i.append) begin
      prim_q[cnt_q[IdxBits-1:0]] <= rp_q;
      sec_q[cnt_q[IdxBits-1:0]]  <= rs_q;
      tag_q[cnt_q[IdxBits-1:0]]  <= rt_q;
    end else if (cmd_i.replace && not_worse_in) begin
      for (int i = 0; i < MaxKeep; i++) begin
        if (IdxBits'(i) >= sel_q) begin
          if (CntBits'(i) + CntBits'(1) < cnt_q) begin
            prim_q[i] <= prim_q[(i + 1) % MaxKeep];
            sec_q[i]  <= sec_q[(i + 1) % MaxKeep];
            tag_q[i]  <= tag_q[(i + 1) % MaxKeep];
          end else if (CntBits'(i) + CntBits'(1) == cnt_q) begin
            prim_q[i] <= rp_q; sec_q[i] <= rs_q; tag_q[i] <= rt_q;
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_empty_o <= 1'b0; out_cnt_o <= '0; out_last_o <= 1'b0;
      out_prim_o <= '0; out_sec_o <= '0; out_tag_o <= '0;
    end else if (cmd_i.emit_load) begin
      out_empty_o <= (cnt_q == '0);
      out_cnt_o   <= drop_q;
      out_last_o  <= last_emit;
      if (cnt_q == '0) begin
        out_prim_o <= '0; out_sec_o <= '0; out_tag_o <= '0;
      end else begin
        out_prim_o <= prim_q[best_q]; out_sec_o <= sec_q[best_q];
        out_tag_o  <= tag_q[best_q];
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(MaxKeep));
  a_append_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |-> (cnt_q < CntBits'(MaxKeep)));
  a_emit_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_load && (cnt_q != '0)) |-> !done_q[best_q]);
endmodule

// File: sv/tkrs_ctrl.sv
// Sequencing state machine of the top-k row selector.
module tkrs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 in_kind_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output tkrs_pkg::dp_cmd_t    cmd_o,
  input  tkrs_pkg::dp_status_t status_i
);
  import tkrs_pkg::*;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StChk   = 6'b000010,
    StScan  = 6'b000100,
    StRepl  = 6'b001000,
    StBest  = 6'b010000,
    StOut   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d, out_free;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  // out register can take a word this cycle
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q; cmd_o = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_row = 1'b1;
          cmd_o.scan_clear = 1'b1;
          state_d = in_kind_i ? StBest : StChk;
        end
      end
      StChk: begin
        if (!status_i.full) begin
          cmd_o.append = 1'b1; state_d = StIdle;
        end else state_d = StScan;
      end
      StScan: begin
        cmd_o.worst_step = 1'b1;
        if (status_i.scan_done) state_d = StRepl;
      end
      StRepl: begin
        cmd_o.replace = 1'b1; state_d = StIdle;
      end
      StBest: begin
        if (status_i.empty) begin
          if (out_free) begin
            cmd_o.emit_load = 1'b1; cmd_o.clear_run = 1'b1; out_valid_d = 1'b1;
            state_d = StIdle;
          end
        end else begin
          cmd_o.best_step = 1'b1;
          if (status_i.scan_done) state_d = StOut;
        end
      end
      StOut: begin
        if (out_free) begin
          cmd_o.emit_load = 1'b1; out_valid_d = 1'b1;
          if (status_i.emit_last) begin
            cmd_o.clear_run = 1'b1; state_d = StIdle;
          end else begin
            cmd_o.scan_clear = 1'b1; state_d = StBest;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; out_valid_q <= out_valid_d;
    end
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q));
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q);
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_load |-> out_free);
endmodule

// File: sv/top_k_row_selector_top.sv
// Top level of the top-k row selector.
// Keeps the best keep_limit rows of a stream ranked by primary key, then by
// secondary key when enabled; an end word emits the held rows best first then
// clears the store. A data row is checked and appended while the store is not
// full; when it is full, a serial worst-row scan over the store is followed by
// a replace step. An end word on an empty store emits an empty marker word;
// otherwise each result word takes one best-row scan over the store and one
// load into the single output register. A word held in the output register
// by m_axis_tready stalls the next load.
module top_k_row_selector_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,  // key_primary, key_secondary, payload
  input  logic         s_axis_tuser,  // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata,  // out_payload, out_primary, out_secondary,
                                      // is_empty, filtered_count, zero pad
  output logic         m_axis_tlast,  // is_last
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [4:0]   cfg_data_i
);
  import tkrs_pkg::*;

  logic [4:0]  keep_q;
  order_cfg_t  ord_q;
  dp_cmd_t     cmd;
  dp_status_t  status;
  logic [KeyBits-1:0] op, os;
  logic [TagBits-1:0] ot;
  logic        olast, oempty;
  logic [31:0] ocnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= 5'd16; ord_q <= '{prim_asc: 1'b1, sec_asc: 1'b1, sec_use: 1'b1};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegKeepLimit: keep_q <= cfg_data_i;
        RegPrimAsc:   ord_q.prim_asc <= cfg_data_i[0];
        RegSecAsc:    ord_q.sec_asc <= cfg_data_i[0];
        RegSecUse:    ord_q.sec_use <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tkrs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_kind_i(s_axis_tuser), .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid), .cmd_o(cmd), .status_i(status)
  );

  tkrs_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status), .ord_i(ord_q),
    .keep_limit_i(keep_q), .in_prim_i(s_axis_tdata[31:0]),
    .in_sec_i(s_axis_tdata[63:32]), .in_tag_i(s_axis_tdata[79:64]),
    .out_prim_o(op), .out_sec_o(os), .out_tag_o(ot), .out_last_o(olast),
    .out_empty_o(oempty), .out_cnt_o(ocnt)
  );

  assign m_axis_tdata = {7'd0, ocnt, oempty, os, op, ot};
  assign m_axis_tlast = olast;
endmodule
